### src/i2ctbe_pkg.sv
`default_nettype none
package i2ctbe_pkg;

	localparam int AddrW = 7;
	localparam int DataW = 8;
	localparam int CntW  = 4;
	localparam int PhW   = 3;

	localparam logic [AddrW-1:0] ADDR_RESET = 7'h68;
	localparam logic [CntW-1:0]  ADDR_BITS  = 4'd7;
	localparam logic [CntW-1:0]  DATA_BITS  = 4'd8;

	localparam logic [1:0] OP_SCL_WR = 2'd0;
	localparam logic [1:0] OP_SDA_WR = 2'd1;
	localparam logic [1:0] OP_SDA_RD = 2'd2;

	localparam logic [PhW-1:0] PH_IDLE     = 3'd0;
	localparam logic [PhW-1:0] PH_ADDRESS  = 3'd1;
	localparam logic [PhW-1:0] PH_DIR      = 3'd2;
	localparam logic [PhW-1:0] PH_DIR_ACK  = 3'd3;
	localparam logic [PhW-1:0] PH_DATA     = 3'd4;
	localparam logic [PhW-1:0] PH_DATA_ACK = 3'd5;

	typedef struct packed {
		logic [1:0]       opcode;
		logic             line_level;
		logic [DataW-1:0] target_byte;
	} item_t;

	typedef struct packed {
		logic             sda_level;
		logic             byte_received;
		logic [DataW-1:0] received_value;
		logic             byte_requested;
	} result_t;

endpackage
`default_nettype wire

### src/i2c_target_bit_engine_core.sv
// Channel  Dir  tdata (low bit up)                   tuser (low bit up)
// s_       in   line_level, target_byte, zero pad    opcode[1:0]
// m_       out  sda_level, received_value, zero pad  byte_received, byte_requested
// cfg_     in   cfg_wdata = target_address, written when cfg_we is high
//
// One beat per cycle is sustained while the output side keeps m_tready high.
// The input register feeds the bus state machine, whose result lands in the output register.
// The input register advances whenever the output register is empty or being taken,
// so a new beat is accepted while a finished result still waits.
// Reset returns the bus to idle with both lines high and the address at 0x68.
`default_nettype none
module i2c_target_bit_engine_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // line_level, target_byte, zero pad
	input  wire [1:0]  s_tuser,   // opcode
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata,  // sda_level, received_value, zero pad
	output logic [1:0] m_tuser,   // byte_received, byte_requested
	input  wire        cfg_we,
	input  wire [6:0]  cfg_wdata
);
	import i2ctbe_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             adv;
	logic [AddrW-1:0] taddr_q;
	result_t          res;
	logic             valid_s2;
	result_t          res_s2;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taddr_q <= ADDR_RESET;
		end else if (cfg_we) begin
			taddr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode      <= s_tuser;
			item_s1.line_level  <= s_tdata[0];
			item_s1.target_byte <= s_tdata[DataW:1];
		end
	end

	i2ctbe_bus_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.item           (item_s1),
		.target_address (taddr_q),
		.result         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.received_value, res_s2.sda_level};
	assign m_tuser  = {res_s2.byte_requested, res_s2.byte_received};

endmodule
`default_nettype wire

### src/i2ctbe_bus_fsm.sv
`default_nettype none
module i2ctbe_bus_fsm (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step,
	input  i2ctbe_pkg::item_t            item,
	input  wire [i2ctbe_pkg::AddrW-1:0]  target_address,
	output i2ctbe_pkg::result_t          result
);
	import i2ctbe_pkg::*;

	logic [PhW-1:0]   phase_q, phase_d;
	logic             scl_q, scl_d;
	logic             sda_q, sda_d;
	logic [CntW-1:0]  cnt_q, cnt_d;
	logic             mwr_q, mwr_d;
	logic [AddrW-1:0] ashift_q, ashift_d;
	logic [DataW-1:0] dshift_q, dshift_d;
	logic             got, req;
	logic [DataW-1:0] got_val;
	logic [CntW-1:0]  cnt_inc;

	assign cnt_inc = cnt_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		cnt_d    = cnt_q;
		mwr_d    = mwr_q;
		ashift_d = ashift_q;
		dshift_d = dshift_q;
		got      = 1'b0;
		got_val  = '0;
		req      = 1'b0;
		case (item.opcode)
			OP_SCL_WR: begin
				scl_d = item.line_level;
				if (!scl_q && item.line_level) begin
					case (phase_q)
						PH_ADDRESS: begin
							ashift_d = {ashift_q[AddrW-2:0], sda_q};
							cnt_d    = cnt_inc;
							if (cnt_inc == ADDR_BITS) begin
								cnt_d   = '0;
								phase_d = PH_DIR;
							end
						end
						PH_DIR: begin
							mwr_d   = ~sda_q;
							phase_d = (ashift_q == target_address) ? PH_DIR_ACK : PH_IDLE;
						end
						PH_DIR_ACK: begin
							sda_d   = 1'b0;
							phase_d = PH_DATA;
							cnt_d   = '0;
							if (!mwr_q) begin
								dshift_d = item.target_byte;
								req      = 1'b1;
							end
						end
						PH_DATA: begin
							cnt_d = cnt_inc;
							if (mwr_q) begin
								dshift_d = {dshift_q[DataW-2:0], sda_q};
								if (cnt_inc == DATA_BITS) begin
									got     = 1'b1;
									got_val = {dshift_q[DataW-2:0], sda_q};
									phase_d = PH_DATA_ACK;
								end
							end else begin
								sda_d    = dshift_q[DataW-1];
								dshift_d = {dshift_q[DataW-2:0], 1'b0};
								if (cnt_inc == DATA_BITS) begin
									phase_d = PH_DATA_ACK;
								end
							end
						end
						PH_DATA_ACK: begin
							if (mwr_q) begin
								sda_d   = 1'b0;
								phase_d = PH_DATA;
								cnt_d   = '0;
							end else if (sda_q) begin
								phase_d = PH_IDLE;
							end else begin
								phase_d  = PH_DATA;
								dshift_d = item.target_byte;
								req      = 1'b1;
								cnt_d    = '0;
							end
						end
						default: begin
							sda_d = 1'b1;
						end
					endcase
				end
			end
			OP_SDA_WR: begin
				if (scl_q) begin
					if (sda_q && !item.line_level) begin
						phase_d  = PH_ADDRESS;
						cnt_d    = '0;
						ashift_d = '0;
					end else if (!sda_q && item.line_level) begin
						phase_d = PH_IDLE;
					end
				end
				sda_d = item.line_level;
			end
			default: begin
			end
		endcase
	end

	assign result.sda_level      = sda_d;
	assign result.byte_received  = got;
	assign result.received_value = got_val;
	assign result.byte_requested = req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			cnt_q    <= '0;
			mwr_q    <= 1'b0;
			ashift_q <= '0;
			dshift_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			cnt_q    <= cnt_d;
			mwr_q    <= mwr_d;
			ashift_q <= ashift_d;
			dshift_q <= dshift_d;
		end
	end

endmodule
`default_nettype wire

### src/i2ctbe_checker.sv
`default_nettype none
module i2ctbe_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata,
	input wire [1:0]  m_tuser
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[8:1] == 8'd0)
		else $error("received value set without a received byte");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("byte received and requested in one beat");

	a_req_ack_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tdata[0])
		else $error("byte requested while SDA released");

endmodule

bind i2c_target_bit_engine_core i2ctbe_checker u_i2ctbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
